FILE: src/psflm_pkg.sv
// shared types and constants of the per-source flit latency monitor
package psflm_pkg;

   localparam int MAX_SOURCES_DEF    = 64;
   localparam int SOURCE_ID_BITS_DEF = 10;

   localparam int SRC_FIELD_W = 10;
   localparam int REQ_DATA_W  = 112;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 192;
   localparam int RSP_USER_W  = 3;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;

   localparam logic [1:0] CMD_RECORD    = 2'd0;
   localparam logic [1:0] CMD_QUERY_ONE = 2'd1;
   localparam logic [1:0] CMD_QUERY_ALL = 2'd2;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_WARM_UP = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd3;
   localparam logic [2:0] STATUS_NO_PKT  = 3'd4;

   localparam logic [23:0] TPUT_MAX = 24'hFFFFFF;
   localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;

   localparam logic       CSR_WARM_UP = 1'b0;
   localparam logic       CSR_RESET   = 1'b1;

   typedef enum logic [1:0] {
      KIND_RECORD,
      KIND_QUERY_ONE,
      KIND_QUERY_ALL,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [SRC_FIELD_W-1:0]   source_id;
      logic                     is_head;
      logic [31:0]              arrival_cycle;
      logic [31:0]              send_cycle;
      logic [31:0]              current_cycle;
   } item_type;

   typedef struct packed {
      logic [31:0] flits;
      logic [31:0] packets;
      logic [47:0] delay_sum;
      logic [31:0] delay_max;
      logic [31:0] last_time;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  source_count;
      logic [31:0] packet_count;
      logic [31:0] flit_count;
      logic [31:0] average_delay;
      logic [31:0] maximum_delay;
      logic [23:0] throughput;
      logic [31:0] last_arrival;
   } result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

FILE: src/psflm_front.sv
// input stage: accepts transfers, classifies the command and queues items
module psflm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [psflm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [psflm_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             item_valid,
   output psflm_pkg::item_type              item,
   input  logic                             item_pop
);

   psflm_pkg::item_type queue_ff [2];
   psflm_pkg::item_type new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      case (req_tuser[1:0])
         psflm_pkg::CMD_RECORD:    new_item.kind = psflm_pkg::KIND_RECORD;
         psflm_pkg::CMD_QUERY_ONE: new_item.kind = psflm_pkg::KIND_QUERY_ONE;
         psflm_pkg::CMD_QUERY_ALL: new_item.kind = psflm_pkg::KIND_QUERY_ALL;
         default:                  new_item.kind = psflm_pkg::KIND_NOP;
      endcase
      new_item.source_id     = req_tdata[9:0];
      new_item.is_head       = req_tuser[2];
      new_item.arrival_cycle = req_tdata[41:10];
      new_item.send_cycle    = req_tdata[73:42];
      new_item.current_cycle = req_tdata[105:74];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: src/psflm_div.sv
// restoring divider, one quotient bit per cycle
module psflm_div (
   input  logic                    clock,
   input  logic                    reset,
   input  psflm_pkg::div_req_type  div_req,
   output psflm_pkg::div_rsp_type  div_rsp
);

   localparam int NW = psflm_pkg::DIV_NUM_W;
   localparam int DW = psflm_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          take;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      take    = (shifted >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
            cnt_ff  <= CW'(NW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= take ? diff[DW-1:0] : shifted[DW-1:0];
            quo_ff <= {quo_ff[NW-2:0], take};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

FILE: src/psflm_back.sv
// execution stage: source table, counter updates, queries and result register
module psflm_back #(
   parameter int MAX_SOURCES    = psflm_pkg::MAX_SOURCES_DEF,
   parameter int SOURCE_ID_BITS = psflm_pkg::SOURCE_ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            warm_up,
   input  logic [31:0]            reset_len,
   input  logic                   item_valid,
   input  psflm_pkg::item_type    item,
   output logic                   item_pop,
   output psflm_pkg::div_req_type div_req,
   input  psflm_pkg::div_rsp_type div_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output psflm_pkg::result_type  rsp_result
);

   localparam int IDX_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
   localparam int SRC_W   = SOURCE_ID_BITS;
   localparam int MAP_D   = 1 << SOURCE_ID_BITS;
   localparam int PKA_W   = 32 + CNT_W;
   localparam int SUMA_W  = 48 + CNT_W;
   localparam int TPA_W   = 24 + CNT_W;
   localparam int NW      = psflm_pkg::DIV_NUM_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_IDX, ST_ENT, ST_QTP, ST_QAV,
      ST_ARD, ST_AENT, ST_ATP, ST_AAV, ST_OUT
   } state_type;

   state_type state_ff;

   logic [IDX_W-1:0]      map_mem [MAP_D];
   logic [SRC_W-1:0]      src_mem [MAX_SOURCES];
   psflm_pkg::entry_type  ent_mem [MAX_SOURCES];

   logic [IDX_W-1:0]      idx_rd_ff, idx_hold_ff;
   logic [SRC_W-1:0]      src_rd_ff;
   psflm_pkg::entry_type  ent_rd_ff, hold_ff;
   logic                  idx_ok_ff;
   logic [CNT_W-1:0]      used_ff;
   logic [CNT_W-1:0]      k_ff;
   psflm_pkg::item_type   cur_ff;
   logic [33:0]           el_ff, el_in;
   psflm_pkg::result_type res_ff, out_ff;
   logic                  rsp_valid_ff;
   psflm_pkg::div_req_type div_ff;
   logic [PKA_W-1:0]      pk_acc_ff, fl_acc_ff;
   logic [SUMA_W-1:0]     sum_acc_ff;
   logic [TPA_W-1:0]      tp_acc_ff;
   logic [31:0]           mx_acc_ff;
   logic                  clr_busy_ff;
   logic [SRC_W-1:0]      clr_addr_ff;

   logic [SRC_W-1:0]      head_src, cur_src;
   logic                  warm;
   logic [IDX_W-1:0]      rd_addr;
   logic                  hit;
   psflm_pkg::entry_type  base, upd;
   logic [31:0]           delay;
   logic [48:0]           sum_wide;
   logic [IDX_W-1:0]      slot;
   logic                  wr_en, map_wr;
   logic                  el_pos;
   logic [31:0]           pk_sat;
   logic [31:0]           fl_sat;
   logic [23:0]           tp_sat;
   logic [23:0]           tput_q;
   logic                  out_load;
   logic                  rsp_valid_in;
   logic                  div_start_in;
   psflm_pkg::result_type res_init, res_out;

   function automatic logic [23:0] tput_of(input logic [31:0] flits,
                                           input logic [NW-1:0] q,
                                           input logic pos);
      logic [23:0] r;
      if (flits == 32'd0) begin
         r = 24'd0;
      end else if (!pos) begin
         r = psflm_pkg::TPUT_MAX;
      end else if (|q[NW-1:24]) begin
         r = psflm_pkg::TPUT_MAX;
      end else begin
         r = q[23:0];
      end
      return r;
   endfunction

   always_comb begin
      head_src = SRC_W'(item.source_id);
      cur_src  = SRC_W'(cur_ff.source_id);
      warm     = ({1'b0, item.arrival_cycle} < ({1'b0, reset_len} + {1'b0, warm_up}));
      el_in    = {2'b0, item.current_cycle} - {2'b0, warm_up} - {2'b0, reset_len};
      el_pos   = !el_ff[33] && (el_ff != 34'd0);
      item_pop = (state_ff == ST_IDLE) && item_valid && !clr_busy_ff;
      rd_addr  = (state_ff == ST_IDX) ? idx_rd_ff : k_ff[IDX_W-1:0];
      hit      = idx_ok_ff && (src_rd_ff == cur_src);

      base     = hit ? ent_rd_ff : '0;
      delay    = (cur_ff.arrival_cycle >= cur_ff.send_cycle) ?
                 (cur_ff.arrival_cycle - cur_ff.send_cycle) : 32'd0;
      sum_wide = {1'b0, base.delay_sum} + {17'd0, delay};
      upd      = base;
      if (cur_ff.is_head) begin
         if (base.packets != 32'hFFFF_FFFF) upd.packets = base.packets + 32'd1;
         upd.delay_sum = sum_wide[48] ? psflm_pkg::SUM_MAX : sum_wide[47:0];
         if (delay > base.delay_max) upd.delay_max = delay;
      end
      if (base.flits != 32'hFFFF_FFFF) upd.flits = base.flits + 32'd1;
      upd.last_time = cur_ff.arrival_cycle - warm_up;

      slot   = hit ? idx_hold_ff : used_ff[IDX_W-1:0];
      wr_en  = (state_ff == ST_ENT) && (cur_ff.kind == psflm_pkg::KIND_RECORD) &&
               (hit || (used_ff != CNT_W'(MAX_SOURCES)));
      map_wr = wr_en && !hit;

      pk_sat = (|pk_acc_ff[PKA_W-1:32]) ? 32'hFFFF_FFFF : pk_acc_ff[31:0];
      fl_sat = (|fl_acc_ff[PKA_W-1:32]) ? 32'hFFFF_FFFF : fl_acc_ff[31:0];
      tp_sat = (|tp_acc_ff[TPA_W-1:24]) ? psflm_pkg::TPUT_MAX : tp_acc_ff[23:0];
      tput_q = tput_of(hold_ff.flits, div_rsp.quo, el_pos);

      out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      div_start_in = ((state_ff == ST_ENT) && (cur_ff.kind != psflm_pkg::KIND_RECORD) &&
                      hit) ||
                     ((state_ff == ST_QTP) && div_rsp.done) ||
                     ((state_ff == ST_ARD) && (k_ff >= used_ff)) ||
                     (state_ff == ST_AENT);

      res_init = '0;
      if ((item.kind == psflm_pkg::KIND_RECORD) && warm) begin
         res_init.status = psflm_pkg::STATUS_WARM_UP;
      end
      res_out              = res_ff;
      res_out.source_count = 7'(used_ff);
   end

   // source map clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == SRC_W'(MAP_D - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_rd_ff <= map_mem[head_src];
      if (clr_busy_ff) begin
         map_mem[clr_addr_ff] <= '0;
      end else if (map_wr) begin
         map_mem[cur_src] <= used_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      src_rd_ff <= src_mem[rd_addr];
      ent_rd_ff <= ent_mem[rd_addr];
      if (wr_en) begin
         src_mem[slot] <= cur_src;
         ent_mem[slot] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_ff.start <= 1'b0;
      end else begin
         div_ff.start <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (item_pop) begin
                  cur_ff     <= item;
                  el_ff      <= el_in;
                  res_ff     <= res_init;
                  k_ff       <= '0;
                  pk_acc_ff  <= '0;
                  fl_acc_ff  <= '0;
                  sum_acc_ff <= '0;
                  tp_acc_ff  <= '0;
                  mx_acc_ff  <= '0;
                  case (item.kind)
                     psflm_pkg::KIND_RECORD: begin
                        if (warm) begin
                           state_ff <= ST_OUT;
                        end else begin
                           state_ff <= ST_IDX;
                        end
                     end
                     psflm_pkg::KIND_QUERY_ONE: state_ff <= ST_IDX;
                     psflm_pkg::KIND_QUERY_ALL: state_ff <= ST_ARD;
                     default:                   state_ff <= ST_OUT;
                  endcase
               end
            end
            ST_IDX: begin
               idx_hold_ff <= idx_rd_ff;
               idx_ok_ff   <= (CNT_W'(idx_rd_ff) < used_ff);
               state_ff    <= ST_ENT;
            end
            ST_ENT: begin
               hold_ff <= ent_rd_ff;
               if (cur_ff.kind == psflm_pkg::KIND_RECORD) begin
                  if (!hit && (used_ff == CNT_W'(MAX_SOURCES))) begin
                     res_ff.status <= psflm_pkg::STATUS_FULL;
                  end else if (!hit) begin
                     used_ff <= used_ff + 1'b1;
                  end
                  state_ff <= ST_OUT;
               end else if (!hit) begin
                  res_ff.status <= psflm_pkg::STATUS_UNKNOWN;
                  state_ff      <= ST_OUT;
               end else begin
                  res_ff.packet_count <= ent_rd_ff.packets;
                  res_ff.flit_count   <= ent_rd_ff.flits;
                  res_ff.last_arrival <= ent_rd_ff.last_time;
                  div_ff.num   <= NW'({ent_rd_ff.flits, 16'd0});
                  div_ff.den   <= el_ff[31:0];
                  state_ff     <= ST_QTP;
               end
            end
            ST_QTP: begin
               if (div_rsp.done) begin
                  res_ff.throughput <= tput_q;
                  div_ff.num   <= NW'(hold_ff.delay_sum);
                  div_ff.den   <= hold_ff.packets;
                  state_ff     <= ST_QAV;
               end
            end
            ST_QAV: begin
               if (div_rsp.done) begin
                  if (hold_ff.packets == 32'd0) begin
                     res_ff.status <= psflm_pkg::STATUS_NO_PKT;
                  end else begin
                     res_ff.average_delay <= div_rsp.quo[31:0];
                     res_ff.maximum_delay <= hold_ff.delay_max;
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_ARD: begin
               if (k_ff < used_ff) begin
                  state_ff <= ST_AENT;
               end else begin
                  div_ff.num   <= NW'(sum_acc_ff);
                  div_ff.den   <= pk_sat;
                  state_ff     <= ST_AAV;
               end
            end
            ST_AENT: begin
               hold_ff    <= ent_rd_ff;
               pk_acc_ff  <= pk_acc_ff + PKA_W'(ent_rd_ff.packets);
               fl_acc_ff  <= fl_acc_ff + PKA_W'(ent_rd_ff.flits);
               sum_acc_ff <= sum_acc_ff + SUMA_W'(ent_rd_ff.delay_sum);
               if (ent_rd_ff.delay_max > mx_acc_ff) mx_acc_ff <= ent_rd_ff.delay_max;
               div_ff.num   <= NW'({ent_rd_ff.flits, 16'd0});
               div_ff.den   <= el_ff[31:0];
               state_ff     <= ST_ATP;
            end
            ST_ATP: begin
               if (div_rsp.done) begin
                  tp_acc_ff <= tp_acc_ff + TPA_W'(tput_q);
                  k_ff      <= k_ff + 1'b1;
                  state_ff  <= ST_ARD;
               end
            end
            ST_AAV: begin
               if (div_rsp.done) begin
                  res_ff.packet_count <= pk_sat;
                  res_ff.flit_count   <= fl_sat;
                  res_ff.throughput   <= tp_sat;
                  if (pk_sat == 32'd0) begin
                     res_ff.status <= psflm_pkg::STATUS_NO_PKT;
                  end else begin
                     res_ff.average_delay <= (|div_rsp.quo[NW-1:32]) ? 32'hFFFF_FFFF :
                                             div_rsp.quo[31:0];
                     res_ff.maximum_delay <= mx_acc_ff;
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  out_ff   <= res_out;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign div_req    = div_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = out_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_SOURCES))
      else $error("source table count beyond capacity");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (used_ff != $past(used_ff)) |-> used_ff == $past(used_ff) + 1'b1)
      else $error("source table count moved by more than one");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_QTP || state_ff == ST_QAV ||
                        state_ff == ST_ATP || state_ff == ST_AAV))
      else $error("divider finished outside a wait state");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (state_ff == ST_IDLE))
      else $error("item started during the source map clearing pass");

endmodule

FILE: src/per_source_flit_latency_monitor.sv
// top level of the per-source flit latency and throughput monitor
//
// req channel carries record and query commands, one transfer per item;
// rsp channel returns exactly one result transfer per item, in order.
// configuration registers warm-up length (0x0) and reset length (0x4)
// are written over the csr port; the user must write them only while
// the block is idle, which the block itself does not enforce.
// a record passes from its request transfer to a valid result through
// source map read, entry read, entry update and result register; a
// record ignored in warm-up or an unused command goes straight to the
// result register. a single-source query makes two passes through the
// serial divider (throughput, then average delay); an aggregate query
// runs one throughput division per used entry and a final average.
// the back end works on one item at a time; a two-entry queue accepts
// new items while it works, and the result register holds a finished
// result while rsp_tready is low; the back end then stalls and the
// queue fills until req_tready drops.
// reset clears the table count, the queue and the result valid, then a
// clearing pass over all 2^SOURCE_ID_BITS map entries (1024 by default)
// zeroes the source map before the first item is taken.
module per_source_flit_latency_monitor #(
   parameter int MAX_SOURCES    = psflm_pkg::MAX_SOURCES_DEF,
   parameter int SOURCE_ID_BITS = psflm_pkg::SOURCE_ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // source_id, arrival_cycle, send_cycle, current_cycle
   input  logic [psflm_pkg::REQ_DATA_W-1:0] req_tdata,
   // command, is_head
   input  logic [psflm_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // source_count, packet_count, flit_count, average_delay, maximum_delay,
   // throughput, last_arrival
   output logic [psflm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [psflm_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic [31:0]            warm_up_ff;
   logic [31:0]            reset_len_ff;
   logic                   csr_wr;
   logic                   item_valid;
   logic                   item_pop;
   psflm_pkg::item_type    item;
   psflm_pkg::div_req_type div_req;
   psflm_pkg::div_rsp_type div_rsp;
   psflm_pkg::result_type  res;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == psflm_pkg::CSR_RESET) ? reset_len_ff : warm_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_up_ff   <= '0;
         reset_len_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == psflm_pkg::CSR_RESET) begin
            reset_len_ff <= csr_pwdata;
         end else begin
            warm_up_ff <= csr_pwdata;
         end
      end
   end

   psflm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   psflm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   psflm_back #(
      .MAX_SOURCES    (MAX_SOURCES),
      .SOURCE_ID_BITS (SOURCE_ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .warm_up    (warm_up_ff),
      .reset_len  (reset_len_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (res)
   );

   assign rsp_tuser = res.status;
   assign rsp_tdata = {1'b0, res.last_arrival, res.throughput, res.maximum_delay,
                       res.average_delay, res.flit_count, res.packet_count,
                       res.source_count};

endmodule
